@@ src/pprb_pkg.sv @@
// Shared types, constants and helpers for the pipe pool ring buffers.
package pprb_pkg;

    localparam int NUM_PIPES      = 8;
    localparam int PIPE_BYTES     = 4096;
    localparam int MAX_READ_BURST = 64;

    localparam int IDX_W   = $clog2(NUM_PIPES);
    localparam int PTR_W   = $clog2(PIPE_BYTES);
    localparam int FILL_W  = PTR_W + 1;
    localparam int LEN_W   = 7;
    localparam int REF_W   = 8;
    localparam int DATA_W  = 8;
    localparam int ADDR_W  = IDX_W + PTR_W;
    localparam int STORE_DEPTH = NUM_PIPES * PIPE_BYTES;

    localparam logic [REF_W-1:0] REF_MAX = 8'd255;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_WRITE   = 3'd1,
        OP_READ    = 3'd2,
        OP_ADDREF  = 3'd3,
        OP_DROPREF = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EOF    = 3'd2,
        ST_AGAIN  = 3'd3,
        ST_NOPIPE = 3'd4,
        ST_REFLIM = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              wend;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] rdata;
        logic [IDX_W-1:0]  new_pipe;
        logic              freed;
        logic              last;
    } result_t;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PIPE_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ src/pprb_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pprb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pprb_front.sv @@
// Front end: accepts request beats, decodes them and queues those with a known operation for the back end.
module pprb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,   // pipe_index[2:0], write_data[10:3], request_length[17:11], write_end[18]
    input  logic [2:0]    s_tuser,   // operation[2:0]
    output logic          q_valid,
    output pprb_pkg::item_t q_item,
    input  logic          q_pop
);
    import pprb_pkg::*;

    item_t            ent_reg [2];
    item_t            ent_next [2];
    logic             head_reg, head_next;
    logic [1:0]       occ_reg, occ_next;
    item_t            dec;
    logic             known;
    logic             push;
    logic [LEN_W-1:0] raw_len;

    always_comb
    begin
        raw_len  = s_tdata[17:11];
        known    = s_tuser <= 3'(OP_DROPREF);
        dec.op   = op_t'(s_tuser);
        dec.idx  = s_tdata[2:0];
        dec.data = s_tdata[10:3];
        dec.len  = (raw_len > LEN_W'(MAX_READ_BURST)) ? LEN_W'(MAX_READ_BURST) : raw_len;
        dec.wend = s_tdata[18];
    end

    assign s_tready = (occ_reg != 2'd2);
    assign push     = s_tvalid && s_tready && known;
    assign q_valid  = (occ_reg != 2'd0);
    assign q_item   = ent_reg[head_reg];

    always_comb
    begin
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        if (push)
        begin
            ent_next[head_reg ^ occ_reg[0]] = dec;
        end
        head_next = head_reg ^ q_pop;
        occ_next  = occ_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            occ_reg  <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

endmodule

@@ src/pprb_back.sv @@
// Back end: slot table, byte store, read burst sequencer and result queue.
module pprb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  pprb_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // read_data[7:0], new_pipe[10:8], pipe_freed[11]
    output logic [2:0]           m_tuser,   // status[2:0]
    output logic                 m_tlast
);
    import pprb_pkg::*;

    logic [PTR_W-1:0]  rptr_reg [NUM_PIPES];
    logic [PTR_W-1:0]  rptr_next [NUM_PIPES];
    logic [PTR_W-1:0]  wptr_reg [NUM_PIPES];
    logic [PTR_W-1:0]  wptr_next [NUM_PIPES];
    logic [FILL_W-1:0] fill_reg [NUM_PIPES];
    logic [FILL_W-1:0] fill_next [NUM_PIPES];
    logic [REF_W-1:0]  rref_reg [NUM_PIPES];
    logic [REF_W-1:0]  rref_next [NUM_PIPES];
    logic [REF_W-1:0]  wref_reg [NUM_PIPES];
    logic [REF_W-1:0]  wref_next [NUM_PIPES];
    logic [NUM_PIPES-1:0] used_reg, used_next;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  bidx_reg, bidx_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              infl_reg, infl_next;
    logic              infl_last_reg, infl_last_next;

    result_t           oent_reg [2];
    result_t           oent_next [2];
    logic              ohead_reg, ohead_next;
    logic [1:0]        oocc_reg, oocc_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    item_t             cur;
    result_t           res;
    logic              push;
    logic              pop_out;
    logic [2:0]        load;
    logic              room;
    logic              live;
    logic              found;
    logic [IDX_W-1:0]  free_idx;
    logic [FILL_W-1:0] n_full;
    logic [REF_W-1:0]  cref;
    logic [REF_W-1:0]  oref;
    logic [REF_W-1:0]  cdec;

    pprb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop_out  = m_tvalid && m_tready;
    assign m_tvalid = (oocc_reg != 2'd0);
    assign m_tdata  = {4'b0, oent_reg[ohead_reg].freed, oent_reg[ohead_reg].new_pipe,
                       oent_reg[ohead_reg].rdata};
    assign m_tuser  = oent_reg[ohead_reg].status;
    assign m_tlast  = oent_reg[ohead_reg].last;

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        fill_next = fill_reg;
        rref_next = rref_reg;
        wref_next = wref_reg;
        used_next = used_reg;
        state_next     = state_reg;
        bidx_next      = bidx_reg;
        cnt_next       = cnt_reg;
        infl_next      = 1'b0;
        infl_last_next = infl_last_reg;

        cur       = q_item;
        live      = used_reg[cur.idx];
        n_full    = (fill_reg[cur.idx] < FILL_W'(cur.len)) ? fill_reg[cur.idx]
                                                             : FILL_W'(cur.len);
        cref      = cur.wend ? wref_reg[cur.idx] : rref_reg[cur.idx];
        oref      = cur.wend ? rref_reg[cur.idx] : wref_reg[cur.idx];
        cdec      = (cref == '0) ? '0 : cref - 1'b1;

        load      = 3'(oocc_reg) + 3'(infl_reg) - 3'(pop_out);
        room      = load < 3'd2;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {cur.idx, wptr_reg[cur.idx]};
        ram_raddr = {bidx_reg, rptr_reg[bidx_reg]};

        push         = 1'b0;
        res.status   = ST_OK;
        res.rdata    = '0;
        res.new_pipe = '0;
        res.freed    = 1'b0;
        res.last     = 1'b1;

        if (infl_reg)
        begin
            push      = 1'b1;
            res.rdata = ram_rdata;
            res.last  = infl_last_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !infl_reg && room)
                begin
                    q_pop = 1'b1;
                    push  = 1'b1;
                    unique case (cur.op)
                        OP_CREATE:
                        begin
                            if (found)
                            begin
                                rptr_next[free_idx] = '0;
                                wptr_next[free_idx] = '0;
                                fill_next[free_idx] = '0;
                                rref_next[free_idx] = REF_W'(1);
                                wref_next[free_idx] = REF_W'(1);
                                used_next[free_idx] = 1'b1;
                                res.new_pipe        = free_idx;
                            end
                            else
                            begin
                                res.status = ST_NOPIPE;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (live && fill_reg[cur.idx] < FILL_W'(PIPE_BYTES))
                            begin
                                ram_we             = 1'b1;
                                wptr_next[cur.idx] = advance(wptr_reg[cur.idx]);
                                fill_next[cur.idx] = fill_reg[cur.idx] + 1'b1;
                            end
                            else
                            begin
                                res.status = ST_FULL;
                            end
                        end
                        OP_READ:
                        begin
                            if (!live)
                            begin
                                res.status = ST_EOF;
                            end
                            else if (n_full == '0)
                            begin
                                res.status = (wref_reg[cur.idx] == '0) ? ST_EOF : ST_AGAIN;
                            end
                            else
                            begin
                                push       = 1'b0;
                                state_next = S_READ;
                                bidx_next  = cur.idx;
                                cnt_next   = LEN_W'(n_full);
                            end
                        end
                        OP_ADDREF:
                        begin
                            if (!live || cref >= REF_MAX)
                            begin
                                res.status = ST_REFLIM;
                            end
                            else if (cur.wend)
                            begin
                                wref_next[cur.idx] = cref + 1'b1;
                            end
                            else
                            begin
                                rref_next[cur.idx] = cref + 1'b1;
                            end
                        end
                        OP_DROPREF:
                        begin
                            if (live)
                            begin
                                if (cur.wend)
                                begin
                                    wref_next[cur.idx] = cdec;
                                end
                                else
                                begin
                                    rref_next[cur.idx] = cdec;
                                end
                                if (cdec == '0 && oref == '0)
                                begin
                                    used_next[cur.idx] = 1'b0;
                                    res.freed          = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (room)
                begin
                    infl_next           = 1'b1;
                    infl_last_next      = (cnt_reg == LEN_W'(1));
                    rptr_next[bidx_reg] = advance(rptr_reg[bidx_reg]);
                    fill_next[bidx_reg] = fill_reg[bidx_reg] - 1'b1;
                    cnt_next            = cnt_reg - 1'b1;
                    if (cnt_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        oent_next[0] = oent_reg[0];
        oent_next[1] = oent_reg[1];
        if (push)
        begin
            oent_next[ohead_reg ^ oocc_reg[0]] = res;
        end
        ohead_next = ohead_reg ^ pop_out;
        oocc_next  = oocc_reg + 2'(push) - 2'(pop_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
                fill_reg[i] <= '0;
                rref_reg[i] <= '0;
                wref_reg[i] <= '0;
            end
            used_reg  <= '0;
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            infl_reg  <= 1'b0;
            ohead_reg <= 1'b0;
            oocc_reg  <= 2'd0;
        end
        else
        begin
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            fill_reg  <= fill_next;
            rref_reg  <= rref_next;
            wref_reg  <= wref_next;
            used_reg  <= used_next;
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            infl_reg  <= infl_next;
            ohead_reg <= ohead_next;
            oocc_reg  <= oocc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bidx_reg      <= bidx_next;
        infl_last_reg <= infl_last_next;
        oent_reg[0]   <= oent_next[0];
        oent_reg[1]   <= oent_next[1];
    end

endmodule

@@ src/pipe_pool_ring_buffers_top.sv @@
// Top level of the pipe pool ring buffers: front end, back end and checks.
// Path: a non-read result beat is registered in the request queue, then in the result queue;
//   the first byte of a read also passes the read state and the store's registered read.
// Throughput: create, write and reference beats one per cycle while the result queue has room; a read
//   holds the back end through decode, one store read per byte and the last registered read.
// Reset: all slots free, pointers, counts and queues cleared; store contents undefined.
module pipe_pool_ring_buffers_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pipe_index[2:0], write_data[10:3], request_length[17:11], write_end[18]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_data[7:0], new_pipe[10:8], pipe_freed[11]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);
    import pprb_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    pprb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pprb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request queue popped while empty");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
        else $error("error status on a non-final beat");

    a_newpipe_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[10:8] != '0) |-> (m_tuser == ST_OK && m_tdata[7:0] == '0))
        else $error("slot number on a failed or data beat");

    a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[11]) |-> (m_tuser == ST_OK && m_tlast))
        else $error("release flag on a bad beat");

endmodule
